### hw/rtl/ied_pkg.sv
// Shared codes, encoding constants and the decoded-effect record for the
// instruction effect decoder. No dependencies.
package ied_pkg;

  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_UNK  = 2'd2;

  localparam logic [1:0] MODE_A64 = 2'd1;
  localparam logic [1:0] MODE_RV  = 2'd2;

  localparam logic [2:0] TERM_NONE    = 3'd0;
  localparam logic [2:0] TERM_RET     = 3'd1;
  localparam logic [2:0] TERM_SYSCALL = 3'd2;
  localparam logic [2:0] TERM_TRAP    = 3'd3;
  localparam logic [2:0] TERM_CALLR   = 3'd4;
  localparam logic [2:0] TERM_JMPR    = 3'd5;

  typedef logic [4:0] form_t;

  localparam form_t F_MORE      = 5'd0;
  localparam form_t F_UNK       = 5'd1;
  localparam form_t F_X_POP     = 5'd2;
  localparam form_t F_X_POPR    = 5'd3;
  localparam form_t F_X_PUSH    = 5'd4;
  localparam form_t F_X_RET     = 5'd5;
  localparam form_t F_X_RETI    = 5'd6;
  localparam form_t F_X_SYSC    = 5'd7;
  localparam form_t F_X_INT3    = 5'd8;
  localparam form_t F_X_CALLR   = 5'd9;
  localparam form_t F_X_JMPR    = 5'd10;
  localparam form_t F_A_LDPPOST = 5'd11;
  localparam form_t F_A_SVC     = 5'd12;
  localparam form_t F_A_BR      = 5'd13;
  localparam form_t F_A_BLR     = 5'd14;
  localparam form_t F_A_RET     = 5'd15;
  localparam form_t F_A_LDR     = 5'd16;
  localparam form_t F_A_LDRPOST = 5'd17;
  localparam form_t F_A_MOV     = 5'd18;
  localparam form_t F_A_LDP     = 5'd19;
  localparam form_t F_R_LD      = 5'd20;
  localparam form_t F_R_ADDI    = 5'd21;
  localparam form_t F_R_RET     = 5'd22;
  localparam form_t F_R_ECALL   = 5'd23;
  localparam form_t F_R_EBREAK  = 5'd24;
  localparam form_t F_R_JALR    = 5'd25;
  localparam form_t F_C_LDSP    = 5'd26;
  localparam form_t F_C_RET     = 5'd27;
  localparam form_t F_C_JR      = 5'd28;
  localparam form_t F_C_JALR    = 5'd29;

  localparam logic [7:0] X_OP_POP_HI  = 8'h58;
  localparam logic [7:0] X_OP_PUSH_HI = 8'h50;
  localparam logic [7:0] X_OP_REXB    = 8'h41;
  localparam logic [7:0] X_OP_RET     = 8'hC3;
  localparam logic [7:0] X_OP_RETI    = 8'hC2;
  localparam logic [7:0] X_OP_ESC     = 8'h0F;
  localparam logic [7:0] X_OP_SYSC    = 8'h05;
  localparam logic [7:0] X_OP_INT3    = 8'hCC;
  localparam logic [7:0] X_OP_GRP5    = 8'hFF;
  localparam logic [2:0] X_GRP5_CALL  = 3'd2;
  localparam logic [2:0] X_GRP5_JMP   = 3'd4;

  localparam logic [31:0] A_LDPPOST_MASK = 32'hFFC003E0;
  localparam logic [31:0] A_LDPPOST_VAL  = 32'hA8C003E0;
  localparam logic [31:0] A_SVC_MASK     = 32'hFFE0001F;
  localparam logic [31:0] A_SVC_VAL      = 32'hD4000001;
  localparam logic [31:0] A_BRANCH_MASK  = 32'hFFFFFC1F;
  localparam logic [31:0] A_BR_VAL       = 32'hD61F0000;
  localparam logic [31:0] A_BLR_VAL      = 32'hD63F0000;
  localparam logic [31:0] A_RET_VAL      = 32'hD65F0000;
  localparam logic [31:0] A_LDR_MASK     = 32'hFFC00000;
  localparam logic [31:0] A_LDR_VAL      = 32'hF9400000;
  localparam logic [31:0] A_LDRPOST_MASK = 32'hFFE00C00;
  localparam logic [31:0] A_LDRPOST_VAL  = 32'hF8400400;
  localparam logic [31:0] A_MOV_MASK     = 32'hFFE0FFE0;
  localparam logic [31:0] A_MOV_VAL      = 32'hAA0003E0;
  localparam logic [31:0] A_LDP_VAL      = 32'hA9400000;

  localparam logic [6:0]  R_OPC_LOAD   = 7'h03;
  localparam logic [6:0]  R_OPC_OPIMM  = 7'h13;
  localparam logic [6:0]  R_OPC_JALR   = 7'h67;
  localparam logic [2:0]  R_F3_LD      = 3'd3;
  localparam logic [2:0]  R_F3_ZERO    = 3'd0;
  localparam logic [31:0] R_RET_WORD   = 32'h00008067;
  localparam logic [31:0] R_ECALL_WORD = 32'h00000073;
  localparam logic [31:0] R_EBRK_WORD  = 32'h00100073;
  localparam logic [4:0]  R_SP         = 5'd2;
  localparam logic [4:0]  R_RA         = 5'd1;
  localparam logic [15:0] C_LDSP_MASK  = 16'hE003;
  localparam logic [15:0] C_LDSP_VAL   = 16'h6002;
  localparam logic [15:0] C_RET_HALF   = 16'h8082;
  localparam logic [15:0] C_JR_MASK    = 16'hF07F;
  localparam logic [15:0] C_JR_VAL     = 16'h8002;
  localparam logic [15:0] C_JALR_VAL   = 16'h9002;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        len;
    logic [2:0]        term;
    logic              mrd;
    logic              mwr;
    logic              wa_en;
    logic [4:0]        wa;
    logic              wb_en;
    logic [4:0]        wb;
    logic              ra_en;
    logic [4:0]        ra;
    logic signed [17:0] delta;
  } effect_t;

endpackage

### hw/rtl/insn_effect_decoder.sv
// Instruction effect decoder: four-stage pipeline from instruction bytes to
// register, stack and control-transfer effects. Depends on ied_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries mode, insn_bytes and
//   bytes_available; one request describes one instruction at its start.
//   Output channel (out_valid/out_stall) returns exactly one result per
//   request, in order.
//   Throughput is one request per cycle while out_stall is low; the stages are
//   input capture, form match, field select and mask expansion.
//   Each stage holds its request only while the stage after it is full and
//   blocked, so bubbles close up under a stall and in_stall rises only when
//   all four stages hold a request and the receiver stalls.
//   Reset clears every stage's valid bit; no request is in flight after it.
//   The decoder keeps no state between requests.
//   A non-decoded status (need more bytes or unrecognised) comes with all
//   effect fields at zero.
module insn_effect_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [31:0]        insn_bytes,
  input  logic [2:0]         bytes_available,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [2:0]         insn_length,
  output logic [31:0]        reg_wr_mask,
  output logic [31:0]        reg_rd_mask,
  output logic signed [17:0] sp_adjust,
  output logic               mem_read,
  output logic               mem_write,
  output logic               known,
  output logic [2:0]         terminator
);
  import ied_pkg::*;

  logic        a_valid, b_valid, c_valid;
  logic        a_en, b_en, c_en, d_en;
  logic [1:0]  a_mode;
  logic [31:0] a_word;
  logic [2:0]  a_avail;
  form_t       b_form;
  form_t       b_form_next;
  logic [31:0] b_word;
  effect_t     c_fx;
  effect_t     c_fx_next;

  logic [7:0]  x_op, x_b1;
  logic [15:0] r_half;

  assign d_en     = !out_valid || !out_stall;
  assign c_en     = !c_valid || d_en;
  assign b_en     = !b_valid || c_en;
  assign a_en     = !a_valid || b_en;
  assign in_stall = !a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_en) a_valid <= in_valid;
      if (b_en) b_valid <= a_valid;
      if (c_en) c_valid <= b_valid;
      if (d_en) out_valid <= c_valid;
    end
  end

  // capture, saturate byte count
  always_ff @(posedge clk) begin
    if (a_en) begin
      a_mode  <= mode;
      a_word  <= insn_bytes;
      a_avail <= (bytes_available > 3'd4) ? 3'd4 : bytes_available;
    end
  end

  assign x_op   = a_word[7:0];
  assign x_b1   = a_word[15:8];
  assign r_half = a_word[15:0];

  // form match
  always_comb begin
    b_form_next = F_UNK;
    if (a_avail == 3'd0) begin
      b_form_next = F_MORE;
    end else if (a_mode == MODE_A64) begin
      if (a_avail < 3'd4) b_form_next = F_MORE;
      else if ((a_word & A_LDPPOST_MASK) == A_LDPPOST_VAL) b_form_next = F_A_LDPPOST;
      else if ((a_word & A_SVC_MASK) == A_SVC_VAL) b_form_next = F_A_SVC;
      else if ((a_word & A_BRANCH_MASK) == A_BR_VAL) b_form_next = F_A_BR;
      else if ((a_word & A_BRANCH_MASK) == A_BLR_VAL) b_form_next = F_A_BLR;
      else if ((a_word & A_BRANCH_MASK) == A_RET_VAL) b_form_next = F_A_RET;
      else if ((a_word & A_LDR_MASK) == A_LDR_VAL) b_form_next = F_A_LDR;
      else if ((a_word & A_LDRPOST_MASK) == A_LDRPOST_VAL) b_form_next = F_A_LDRPOST;
      else if ((a_word & A_MOV_MASK) == A_MOV_VAL) b_form_next = F_A_MOV;
      else if ((a_word & A_LDR_MASK) == A_LDP_VAL) b_form_next = F_A_LDP;
    end else if (a_mode == MODE_RV) begin
      if (a_avail < 3'd2) begin
        b_form_next = F_MORE;
      end else if (a_word[1:0] == 2'b11) begin
        if (a_avail < 3'd4) b_form_next = F_MORE;
        else if (a_word[6:0] == R_OPC_LOAD && a_word[14:12] == R_F3_LD) b_form_next = F_R_LD;
        else if (a_word[6:0] == R_OPC_OPIMM && a_word[14:12] == R_F3_ZERO)
          b_form_next = F_R_ADDI;
        else if (a_word == R_RET_WORD) b_form_next = F_R_RET;
        else if (a_word == R_ECALL_WORD) b_form_next = F_R_ECALL;
        else if (a_word == R_EBRK_WORD) b_form_next = F_R_EBREAK;
        else if (a_word[6:0] == R_OPC_JALR && a_word[14:12] == R_F3_ZERO)
          b_form_next = F_R_JALR;
      end else begin
        if ((r_half & C_LDSP_MASK) == C_LDSP_VAL) b_form_next = F_C_LDSP;
        else if (r_half == C_RET_HALF) b_form_next = F_C_RET;
        else if ((r_half & C_JR_MASK) == C_JR_VAL && r_half[11:7] != 5'd0)
          b_form_next = F_C_JR;
        else if ((r_half & C_JR_MASK) == C_JALR_VAL && r_half[11:7] != 5'd0)
          b_form_next = F_C_JALR;
      end
    end else begin
      if (x_op[7:3] == X_OP_POP_HI[7:3]) b_form_next = F_X_POP;
      else if (x_op == X_OP_REXB && a_avail >= 3'd2 && x_b1[7:3] == X_OP_POP_HI[7:3])
        b_form_next = F_X_POPR;
      else if (x_op[7:3] == X_OP_PUSH_HI[7:3]) b_form_next = F_X_PUSH;
      else if (x_op == X_OP_RET) b_form_next = F_X_RET;
      else if (x_op == X_OP_RETI && a_avail >= 3'd3) b_form_next = F_X_RETI;
      else if (x_op == X_OP_ESC && a_avail >= 3'd2 && x_b1 == X_OP_SYSC) b_form_next = F_X_SYSC;
      else if (x_op == X_OP_INT3) b_form_next = F_X_INT3;
      else if (x_op == X_OP_GRP5 && a_avail >= 3'd2 && x_b1[7:6] == 2'b11) begin
        if (x_b1[5:3] == X_GRP5_CALL) b_form_next = F_X_CALLR;
        else if (x_b1[5:3] == X_GRP5_JMP) b_form_next = F_X_JMPR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_form <= b_form_next;
      b_word <= a_word;
    end
  end

  // field select
  always_comb begin
    c_fx_next        = '0;
    c_fx_next.status = ST_OK;
    unique case (b_form) inside
      F_MORE: c_fx_next.status = ST_MORE;
      F_UNK:  c_fx_next.status = ST_UNK;
      F_X_POP: begin
        c_fx_next.len = 3'd1; c_fx_next.mrd = 1'b1; c_fx_next.delta = 18'sd8;
        c_fx_next.wa_en = 1'b1; c_fx_next.wa = {2'b00, b_word[2:0]};
      end
      F_X_POPR: begin
        c_fx_next.len = 3'd2; c_fx_next.mrd = 1'b1; c_fx_next.delta = 18'sd8;
        c_fx_next.wa_en = 1'b1; c_fx_next.wa = {2'b01, b_word[10:8]};
      end
      F_X_PUSH: begin
        c_fx_next.len = 3'd1; c_fx_next.mwr = 1'b1; c_fx_next.delta = -18'sd8;
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = {2'b00, b_word[2:0]};
      end
      F_X_RET: begin
        c_fx_next.len = 3'd1; c_fx_next.mrd = 1'b1; c_fx_next.delta = 18'sd8;
        c_fx_next.term = TERM_RET;
      end
      F_X_RETI: begin
        c_fx_next.len = 3'd3; c_fx_next.mrd = 1'b1; c_fx_next.term = TERM_RET;
        c_fx_next.delta = 18'sd8 + $signed({2'b00, b_word[23:8]});
      end
      F_X_SYSC:  begin c_fx_next.len = 3'd2; c_fx_next.term = TERM_SYSCALL; end
      F_X_INT3:  begin c_fx_next.len = 3'd1; c_fx_next.term = TERM_TRAP; end
      F_X_CALLR: begin c_fx_next.len = 3'd2; c_fx_next.term = TERM_CALLR; end
      F_X_JMPR:  begin c_fx_next.len = 3'd2; c_fx_next.term = TERM_JMPR; end
      F_A_LDPPOST: begin
        c_fx_next.len = 3'd4; c_fx_next.mrd = 1'b1;
        c_fx_next.wa_en = 1'b1; c_fx_next.wa = b_word[4:0];
        c_fx_next.wb_en = 1'b1; c_fx_next.wb = b_word[14:10];
        c_fx_next.delta = $signed({{8{b_word[21]}}, b_word[21:15], 3'b000});
      end
      F_A_SVC: begin c_fx_next.len = 3'd4; c_fx_next.term = TERM_SYSCALL; end
      F_A_BR, F_A_BLR, F_A_RET: begin
        c_fx_next.len = 3'd4;
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = b_word[9:5];
        c_fx_next.term = (b_form == F_A_BR) ? TERM_JMPR :
                         (b_form == F_A_BLR) ? TERM_CALLR : TERM_RET;
      end
      F_A_LDR: begin
        c_fx_next.len = 3'd4; c_fx_next.mrd = 1'b1;
        c_fx_next.wa_en = 1'b1; c_fx_next.wa = b_word[4:0];
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = b_word[9:5];
      end
      F_A_LDRPOST: begin
        c_fx_next.len = 3'd4; c_fx_next.mrd = 1'b1;
        c_fx_next.wa_en = 1'b1; c_fx_next.wa = b_word[4:0];
        c_fx_next.ra_en = (b_word[9:5] != b_word[4:0]); c_fx_next.ra = b_word[9:5];
      end
      F_A_MOV: begin
        c_fx_next.len = 3'd4;
        c_fx_next.wa_en = 1'b1; c_fx_next.wa = b_word[4:0];
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = b_word[20:16];
      end
      F_A_LDP: begin
        c_fx_next.len = 3'd4; c_fx_next.mrd = 1'b1;
        c_fx_next.wa_en = 1'b1; c_fx_next.wa = b_word[4:0];
        c_fx_next.wb_en = 1'b1; c_fx_next.wb = b_word[14:10];
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = b_word[9:5];
      end
      F_R_LD: begin
        c_fx_next.len = 3'd4; c_fx_next.mrd = 1'b1;
        c_fx_next.wa_en = (b_word[11:7] != 5'd0); c_fx_next.wa = b_word[11:7];
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = b_word[19:15];
      end
      F_R_ADDI: begin
        c_fx_next.len = 3'd4;
        c_fx_next.wa_en = (b_word[11:7] != 5'd0); c_fx_next.wa = b_word[11:7];
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = b_word[19:15];
        if (b_word[11:7] == R_SP && b_word[19:15] == R_SP)
          c_fx_next.delta = $signed({{6{b_word[31]}}, b_word[31:20]});
      end
      F_R_RET: begin
        c_fx_next.len = 3'd4; c_fx_next.term = TERM_RET;
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = R_RA;
      end
      F_R_ECALL:  begin c_fx_next.len = 3'd4; c_fx_next.term = TERM_SYSCALL; end
      F_R_EBREAK: begin c_fx_next.len = 3'd4; c_fx_next.term = TERM_TRAP; end
      F_R_JALR: begin
        c_fx_next.len = 3'd4; c_fx_next.term = TERM_CALLR;
        c_fx_next.ra_en = 1'b1; c_fx_next.ra = b_word[19:15];
      end
      F_C_LDSP: begin
        c_fx_next.len = 3'd2; c_fx_next.mrd = 1'b1;
        c_fx_next.wa_en = (b_word[11:7] != 5'd0); c_fx_next.wa = b_word[11:7];
      end
      F_C_RET:  begin c_fx_next.len = 3'd2; c_fx_next.term = TERM_RET; end
      F_C_JR:   begin c_fx_next.len = 3'd2; c_fx_next.term = TERM_JMPR; end
      F_C_JALR: begin c_fx_next.len = 3'd2; c_fx_next.term = TERM_CALLR; end
      default:  c_fx_next.status = ST_UNK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_en) c_fx <= c_fx_next;
  end

  // expand register masks
  always_ff @(posedge clk) begin
    if (d_en) begin
      status      <= c_fx.status;
      insn_length <= c_fx.len;
      reg_wr_mask <= ({31'd0, c_fx.wa_en} << c_fx.wa) | ({31'd0, c_fx.wb_en} << c_fx.wb);
      reg_rd_mask <= {31'd0, c_fx.ra_en} << c_fx.ra;
      sp_adjust   <= c_fx.delta;
      mem_read    <= c_fx.mrd;
      mem_write   <= c_fx.mwr;
      known       <= (c_fx.status == ST_OK);
      terminator  <= c_fx.term;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && b_valid && c_valid && out_valid && out_stall))
    else $error("input stalled with a free stage");

  a_not_decoded_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (reg_wr_mask == 32'd0 && reg_rd_mask == 32'd0 &&
      sp_adjust == 18'sd0 && terminator == TERM_NONE && insn_length == 3'd0 && !known))
    else $error("effect fields set on a non-decoded result");

  a_decoded_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> (insn_length != 3'd0 && known))
    else $error("decoded result without length");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (c_valid && !c_en) |=> (c_valid && $stable(c_fx)))
    else $error("blocked stage lost its request");

endmodule

### verif/insn_effect_decoder_chk.sv
`timescale 1ns / 100ps
// Result checker for insn_effect_decoder: predicts the effect of every accepted
// request, compares each accepted result against the oldest prediction.
// Depends on ied_pkg for status, mode, terminator and encoding constants.
module insn_effect_decoder_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [31:0]        insn_bytes,
  input  logic [2:0]         bytes_available,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic [2:0]         insn_length,
  input  logic [31:0]        reg_wr_mask,
  input  logic [31:0]        reg_rd_mask,
  input  logic signed [17:0] sp_adjust,
  input  logic               mem_read,
  input  logic               mem_write,
  input  logic               known,
  input  logic [2:0]         terminator,
  output int                 fail_count,
  output int                 outstanding
);
  import ied_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         len;
    logic [31:0]        wr;
    logic [31:0]        rd;
    logic signed [17:0] delta;
    logic               mrd;
    logic               mwr;
    logic               known;
    logic [2:0]         term;
  } fx_rec_t;

  fx_rec_t expected_effects[$];
  int mismatch_cnt = 0;

  function automatic fx_rec_t predict_effect(input logic [1:0] md, input logic [31:0] w,
                                             input logic [2:0] av_raw);
    fx_rec_t e;
    logic [1:0] st;
    logic [2:0] av;
    logic [7:0] op, b1, b2;
    logic [4:0] r0, r5, r10, rs1, rdn;
    logic [15:0] h;
    logic [6:0] imm7;
    logic [11:0] imm12;
    e = '0;
    av = (av_raw > 3'd4) ? 3'd4 : av_raw;
    op = w[7:0];
    b1 = w[15:8];
    b2 = w[23:16];
    r0 = w[4:0];
    r5 = w[9:5];
    r10 = w[14:10];
    rs1 = w[19:15];
    rdn = w[11:7];
    h = w[15:0];
    imm7 = w[21:15];
    imm12 = w[31:20];
    if (av == 3'd0) begin
      e.status = ST_MORE;
    end else if (md == MODE_A64) begin
      if (av < 3'd4) begin
        e.status = ST_MORE;
      end else begin
        e.status = ST_OK;
        e.len = 3'd4;
        if ((w & A_LDPPOST_MASK) == A_LDPPOST_VAL) begin
          e.wr = (32'd1 << r0) | (32'd1 << r10);
          e.delta = {{8{imm7[6]}}, imm7, 3'b000};
          e.mrd = 1'b1;
        end else if ((w & A_SVC_MASK) == A_SVC_VAL) begin
          e.term = TERM_SYSCALL;
        end else if ((w & A_BRANCH_MASK) == A_BR_VAL) begin
          e.term = TERM_JMPR;
          e.rd = 32'd1 << r5;
        end else if ((w & A_BRANCH_MASK) == A_BLR_VAL) begin
          e.term = TERM_CALLR;
          e.rd = 32'd1 << r5;
        end else if ((w & A_BRANCH_MASK) == A_RET_VAL) begin
          e.term = TERM_RET;
          e.rd = 32'd1 << r5;
        end else if ((w & A_LDR_MASK) == A_LDR_VAL) begin
          e.wr = 32'd1 << r0;
          e.rd = 32'd1 << r5;
          e.mrd = 1'b1;
        end else if ((w & A_LDRPOST_MASK) == A_LDRPOST_VAL) begin
          e.wr = 32'd1 << r0;
          if (r5 != r0) e.rd = 32'd1 << r5;
          e.mrd = 1'b1;
        end else if ((w & A_MOV_MASK) == A_MOV_VAL) begin
          e.wr = 32'd1 << r0;
          e.rd = 32'd1 << w[20:16];
        end else if ((w & A_LDR_MASK) == A_LDP_VAL) begin
          e.wr = (32'd1 << r0) | (32'd1 << r10);
          e.rd = 32'd1 << r5;
          e.mrd = 1'b1;
        end else begin
          e.status = ST_UNK;
        end
      end
    end else if (md == MODE_RV) begin
      if (av < 3'd2) begin
        e.status = ST_MORE;
      end else if (w[1:0] == 2'b11) begin
        if (av < 3'd4) begin
          e.status = ST_MORE;
        end else begin
          e.status = ST_OK;
          e.len = 3'd4;
          if (w[6:0] == R_OPC_LOAD && w[14:12] == R_F3_LD) begin
            if (rdn != 5'd0) e.wr = 32'd1 << rdn;
            e.rd = 32'd1 << rs1;
            e.mrd = 1'b1;
          end else if (w[6:0] == R_OPC_OPIMM && w[14:12] == R_F3_ZERO) begin
            if (rdn != 5'd0) e.wr = 32'd1 << rdn;
            e.rd = 32'd1 << rs1;
            if (rdn == R_SP && rs1 == R_SP) e.delta = {{6{imm12[11]}}, imm12};
          end else if (w == R_RET_WORD) begin
            e.term = TERM_RET;
            e.rd = 32'd1 << R_RA;
          end else if (w == R_ECALL_WORD) begin
            e.term = TERM_SYSCALL;
          end else if (w == R_EBRK_WORD) begin
            e.term = TERM_TRAP;
          end else if (w[6:0] == R_OPC_JALR && w[14:12] == R_F3_ZERO) begin
            e.term = TERM_CALLR;
            e.rd = 32'd1 << rs1;
          end else begin
            e.status = ST_UNK;
          end
        end
      end else begin
        e.status = ST_OK;
        e.len = 3'd2;
        if ((h & C_LDSP_MASK) == C_LDSP_VAL) begin
          if (rdn != 5'd0) e.wr = 32'd1 << rdn;
          e.mrd = 1'b1;
        end else if (h == C_RET_HALF) begin
          e.term = TERM_RET;
        end else if ((h & C_JR_MASK) == C_JR_VAL && rdn != 5'd0) begin
          e.term = TERM_JMPR;
        end else if ((h & C_JR_MASK) == C_JALR_VAL && rdn != 5'd0) begin
          e.term = TERM_CALLR;
        end else begin
          e.status = ST_UNK;
        end
      end
    end else begin
      e.status = ST_OK;
      e.len = 3'd1;
      if (op[7:3] == X_OP_POP_HI[7:3]) begin
        e.wr = 32'd1 << op[2:0];
        e.delta = 18'sd8;
        e.mrd = 1'b1;
      end else if (op == X_OP_REXB && av >= 3'd2 && b1[7:3] == X_OP_POP_HI[7:3]) begin
        e.wr = 32'd1 << {2'b01, b1[2:0]};
        e.delta = 18'sd8;
        e.mrd = 1'b1;
        e.len = 3'd2;
      end else if (op[7:3] == X_OP_PUSH_HI[7:3]) begin
        e.rd = 32'd1 << op[2:0];
        e.delta = -18'sd8;
        e.mwr = 1'b1;
      end else if (op == X_OP_RET) begin
        e.delta = 18'sd8;
        e.mrd = 1'b1;
        e.term = TERM_RET;
      end else if (op == X_OP_RETI && av >= 3'd3) begin
        e.delta = 18'd8 + {2'b00, b2, b1};
        e.mrd = 1'b1;
        e.term = TERM_RET;
        e.len = 3'd3;
      end else if (op == X_OP_ESC && av >= 3'd2 && b1 == X_OP_SYSC) begin
        e.term = TERM_SYSCALL;
        e.len = 3'd2;
      end else if (op == X_OP_INT3) begin
        e.term = TERM_TRAP;
      end else if (op == X_OP_GRP5 && av >= 3'd2 && b1[7:6] == 2'b11 &&
                   b1[5:3] == X_GRP5_CALL) begin
        e.term = TERM_CALLR;
        e.len = 3'd2;
      end else if (op == X_OP_GRP5 && av >= 3'd2 && b1[7:6] == 2'b11 &&
                   b1[5:3] == X_GRP5_JMP) begin
        e.term = TERM_JMPR;
        e.len = 3'd2;
      end else begin
        e.status = ST_UNK;
      end
    end
    if (e.status != ST_OK) begin
      st = e.status;
      e = '0;
      e.status = st;
    end
    e.known = (e.status == ST_OK);
    return e;
  endfunction

  task automatic show_effect(input string tag, input fx_rec_t e);
    $display("  %s status=%0d len=%0d wr=%h rd=%h delta=%0d mrd=%0b mwr=%0b known=%0b term=%0d",
             tag, e.status, e.len, e.wr, e.rd, e.delta, e.mrd, e.mwr, e.known, e.term);
  endtask

  always @(posedge clk) begin
    fx_rec_t got, want;
    if (rst) begin
      expected_effects.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_effects.push_back(predict_effect(mode, insn_bytes, bytes_available));
      if (out_valid && !out_stall) begin
        got = '{status, insn_length, reg_wr_mask, reg_rd_mask, sp_adjust,
                mem_read, mem_write, known, terminator};
        if (expected_effects.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: result with no request pending", $realtime);
            show_effect("actual  ", got);
          end
        end else begin
          want = expected_effects.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: result mismatch", $realtime);
              show_effect("expected", want);
              show_effect("actual  ", got);
            end
          end
        end
      end
    end
    fail_count <= mismatch_cnt;
    outstanding <= expected_effects.size();
  end

endmodule

### verif/insn_effect_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench top for insn_effect_decoder: drives directed and random requests
// under varying idle and stall pressure and gives the verdict.
// Depends on ied_pkg, insn_effect_decoder and insn_effect_decoder_chk.
module insn_effect_decoder_tb;
  import ied_pkg::*;

  localparam logic [1:0] MODE_X86     = 2'd0;
  localparam logic [1:0] MODE_X86_ALT = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_X86;
  logic [31:0]        insn_bytes = 32'd0;
  logic [2:0]         bytes_available = 3'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [2:0]         insn_length;
  logic [31:0]        reg_wr_mask;
  logic [31:0]        reg_rd_mask;
  logic signed [17:0] sp_adjust;
  logic               mem_read;
  logic               mem_write;
  logic               known;
  logic [2:0]         terminator;

  int fails;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;

  always #4 clk = ~clk;

  insn_effect_decoder dut (.*);

  insn_effect_decoder_chk chk (.*, .fail_count(fails), .outstanding(outstanding));

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_req(input logic [1:0] md, input logic [31:0] w, input logic [2:0] av);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    insn_bytes <= w;
    bytes_available <= av;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word(input logic [1:0] md);
    logic [31:0] r;
    logic [4:0] rg;
    r = $urandom;
    rg = 5'($urandom_range(31));
    if ($urandom_range(99) < 15) return r;
    if (md == MODE_A64) begin
      case ($urandom_range(8))
        0: return A_LDPPOST_VAL | (r & ~A_LDPPOST_MASK);
        1: return A_SVC_VAL | (r & ~A_SVC_MASK);
        2: return A_BR_VAL | (r & ~A_BRANCH_MASK);
        3: return A_BLR_VAL | (r & ~A_BRANCH_MASK);
        4: return A_RET_VAL | (r & ~A_BRANCH_MASK);
        5: return A_LDR_VAL | (r & ~A_LDR_MASK);
        6: return A_LDRPOST_VAL | (r & ~A_LDRPOST_MASK);
        7: return A_MOV_VAL | (r & ~A_MOV_MASK);
        default: return A_LDP_VAL | (r & ~A_LDR_MASK);
      endcase
    end else if (md == MODE_RV) begin
      case ($urandom_range(9))
        0: return {r[31:15], R_F3_LD, r[11:7], R_OPC_LOAD};
        1: return {r[31:15], R_F3_ZERO, r[11:7], R_OPC_OPIMM};
        2: return {r[31:20], R_SP, R_F3_ZERO, R_SP, R_OPC_OPIMM};
        3: return R_RET_WORD;
        4: return R_ECALL_WORD;
        5: return R_EBRK_WORD;
        6: return {r[31:15], R_F3_ZERO, r[11:7], R_OPC_JALR};
        7: return {r[31:16], C_LDSP_VAL | (r[15:0] & ~C_LDSP_MASK)};
        8: return {r[31:16], C_RET_HALF};
        default: return {r[31:16], (r[12] ? C_JALR_VAL : C_JR_VAL) | {4'b0, rg, 7'b0}};
      endcase
    end else begin
      case ($urandom_range(7))
        0: return {r[31:8], X_OP_POP_HI | {5'b0, rg[2:0]}};
        1: return {r[31:16], X_OP_POP_HI | {5'b0, rg[2:0]}, X_OP_REXB};
        2: return {r[31:8], X_OP_PUSH_HI | {5'b0, rg[2:0]}};
        3: return {r[31:8], X_OP_RET};
        4: return {r[31:8], X_OP_RETI};
        5: return {r[31:16], X_OP_SYSC, X_OP_ESC};
        6: return {r[31:8], X_OP_INT3};
        default: return {r[31:16], (r[4] ? 2'b11 : r[7:6]),
                         (r[5] ? r[13:11] : (r[15] ? X_GRP5_CALL : X_GRP5_JMP)),
                         r[10:8], X_OP_GRP5};
      endcase
    end
  endfunction

  initial begin
    logic [1:0] md;
    logic [2:0] av;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_req(MODE_X86, {24'h0, X_OP_POP_HI}, 3'd1);
    send_req(MODE_X86, {16'h0, X_OP_POP_HI | 8'h07, X_OP_REXB}, 3'd2);
    send_req(MODE_X86, {16'h0, X_OP_POP_HI | 8'h07, X_OP_REXB}, 3'd1);
    send_req(MODE_X86, {24'hFFFFFF, X_OP_PUSH_HI | 8'h07}, 3'd4);
    send_req(MODE_X86_ALT, {24'h0, X_OP_RET}, 3'd7);
    send_req(MODE_X86, {8'h0, 16'hFFFF, X_OP_RETI}, 3'd3);
    send_req(MODE_X86, {8'h0, 16'hFFFF, X_OP_RETI}, 3'd2);
    send_req(MODE_X86, {16'h0, X_OP_SYSC, X_OP_ESC}, 3'd2);
    send_req(MODE_X86, {16'h0, X_OP_SYSC, X_OP_ESC}, 3'd1);
    send_req(MODE_X86, {24'h0, X_OP_INT3}, 3'd4);
    send_req(MODE_X86, {16'h0, 2'b11, X_GRP5_CALL, 3'd7, X_OP_GRP5}, 3'd2);
    send_req(MODE_X86, {16'h0, 2'b11, X_GRP5_JMP, 3'd0, X_OP_GRP5}, 3'd4);
    send_req(MODE_X86, 32'hFFFFFFFF, 3'd0);
    send_req(MODE_A64, A_LDPPOST_VAL | (32'h40 << 15) | (32'd30 << 10) | 32'd29, 3'd4);
    send_req(MODE_A64, A_LDPPOST_VAL | (32'h3F << 15) | (32'd31 << 10) | 32'd31, 3'd4);
    send_req(MODE_A64, A_SVC_VAL | 32'h001FFFE0, 3'd4);
    send_req(MODE_A64, A_BLR_VAL | (32'd31 << 5), 3'd5);
    send_req(MODE_A64, A_RET_VAL | (32'd30 << 5), 3'd4);
    send_req(MODE_A64, A_LDRPOST_VAL | (32'd3 << 5) | 32'd3, 3'd4);
    send_req(MODE_A64, A_MOV_VAL | (32'd31 << 16), 3'd4);
    send_req(MODE_A64, A_LDP_VAL | 32'h003FFFFF, 3'd3);
    send_req(MODE_RV, {12'h800, R_SP, R_F3_ZERO, R_SP, R_OPC_OPIMM}, 3'd4);
    send_req(MODE_RV, {12'h7FF, R_SP, R_F3_LD, 5'd0, R_OPC_LOAD}, 3'd4);
    send_req(MODE_RV, R_RET_WORD, 3'd3);
    send_req(MODE_RV, R_EBRK_WORD, 3'd4);
    send_req(MODE_RV, {16'hFFFF, C_LDSP_VAL}, 3'd2);
    send_req(MODE_RV, {16'h0, C_JALR_VAL}, 3'd2);
    send_req(MODE_RV, {16'h0, C_RET_HALF}, 3'd1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int i = 0; i < 100; i++) begin
        md = 2'($urandom_range(3));
        av = ($urandom_range(99) < 75) ? 3'd4 : 3'($urandom_range(7));
        send_req(md, pick_word(md), av);
      end
      // hold off until the pipeline is empty
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ied_pkg.sv
hw/rtl/insn_effect_decoder.sv
verif/insn_effect_decoder_chk.sv
verif/insn_effect_decoder_tb.sv
